// File: design/hcbp_pkg.sv
// shared types and constants for the prefix-code bit packer
// no dependencies; compiled first

package hcbp_pkg;

    localparam int SYM_W      = 8;
    localparam int TBL_DEPTH  = 256;
    localparam int CODE_W     = 32;
    localparam int LEN_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // longest code the packer honours; longer lengths saturate
    localparam int MAX_CODE_LEN = 32;
    localparam int CAP_LEN_I    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP_LEN_I);

    // up to seven pending bits plus one code give four bytes, finish adds a fifth
    localparam int MAX_WORDS = 5;
    localparam int EMIT_W    = MAX_WORDS * BYTE_W;
    localparam int CNT_W     = 3;
    localparam int PCNT_W    = 3;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_END_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_LEN  = 1'd1;

    typedef struct packed {
        logic             en;
        logic [SYM_W-1:0] addr;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0] len;
    } tbl_wr_t;

    typedef struct packed {
        logic             en;
        logic [SYM_W-1:0] addr;
    } tbl_rd_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } tbl_entry_t;

    function automatic logic [LEN_W-1:0] cap_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = (len > CAP_LEN) ? CAP_LEN : len;
        return res;
    endfunction

endpackage

// File: design/hcbp_if.sv
// valid/ready channels of the prefix-code bit packer: input items and output words
// depends on hcbp_pkg

interface hcbp_item_if import hcbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;

    modport source (output valid, func, symbol, code_bits, code_length, input ready);
    modport sink   (input valid, func, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_word_if import hcbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

// File: design/hcbp_table.sv
// code table: code and length memories with registered read
// depends on hcbp_pkg; lengths read as zero until their entry is written

module hcbp_table import hcbp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  tbl_wr_t    wr,
    input  tbl_rd_t    rd,
    output tbl_entry_t rd_data
);

    logic [CODE_W-1:0]    code_mem [TBL_DEPTH];
    logic [LEN_W-1:0]     len_mem  [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] valid_reg;
    logic [CODE_W-1:0]    rd_code_reg;
    logic [LEN_W-1:0]     rd_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            code_mem[wr.addr] <= wr.code;
            len_mem[wr.addr]  <= wr.len;
        end
        if (rd.en)
        begin
            rd_code_reg <= code_mem[rd.addr];
            rd_len_reg  <= valid_reg[rd.addr] ? len_mem[rd.addr] : '0;
        end
    end

    assign rd_data.code = rd_code_reg;
    assign rd_data.len  = rd_len_reg;

endmodule

// File: design/huffman_code_bit_packer.sv
// top level of the prefix-code bit packer: table, merge stage and byte emitter
// depends on hcbp_pkg, hcbp_if and hcbp_table
//
//   channel | role   | handshake        | payload
//   items   | sink   | valid and ready  | func, symbol, code_bits, code_length
//   words   | source | valid and ready  | out_byte, last
//   cfg     | write  | cfg_we only      | cfg_index, cfg_data
//
// an item is taken when valid and ready meet; an encode reads the code table there
// and the merge stage joins the code with the pending bits once the emitter is idle
// the emitter sends one word per cycle while words.ready is high; an item's words
// hold the merge stage until all are sent, one giving none passes at one per cycle
// loads write the table at the accepting edge and never enter the merge stage
// reset clears the pending bits, the emitter, the table valid bits and end_bits_reg
// a stalled words channel holds the emitter, then the merge stage, then items.ready

module huffman_code_bit_packer import hcbp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    hcbp_item_if.sink             items,
    hcbp_word_if.source           words,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [CODE_W-1:0] end_bits_reg;
    logic [LEN_W-1:0]  end_len_reg;

    // merge stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_finish_reg;
    logic              s1_fire;

    // bit accumulator, earliest bit in bit 7, zeros below the pending bits
    logic [BYTE_W-1:0] pend_reg;
    logic [BYTE_W-1:0] pend_next;
    logic [PCNT_W-1:0] pcnt_reg;
    logic [PCNT_W-1:0] pcnt_next;

    // byte emitter
    logic [EMIT_W-1:0] emit_reg;
    logic [CNT_W-1:0]  emit_cnt_reg;

    logic              accept;
    logic              word_taken;
    tbl_wr_t           tbl_wr;
    tbl_rd_t           tbl_rd;
    tbl_entry_t        tbl_q;

    logic [CODE_W-1:0] s1_code;
    logic [LEN_W-1:0]  s1_len;
    logic [LEN_W-1:0]  align_sh;
    logic [CODE_W-1:0] code_al;
    logic [EMIT_W-1:0] merged;
    logic [LEN_W-1:0]  total;
    logic [CNT_W-1:0]  full_bytes;
    logic [PCNT_W-1:0] tail_bits;
    logic [BYTE_W-1:0] tail_byte;
    logic [CNT_W-1:0]  emit_n;

    // handshakes
    assign s1_fire      = s1_valid_reg && (emit_cnt_reg == '0);
    assign items.ready  = !s1_valid_reg || s1_fire;
    assign accept       = items.valid && items.ready;
    assign word_taken   = words.valid && words.ready;

    // table access straight from the accepted item
    assign tbl_wr.en    = accept && (items.func == FUNC_LOAD);
    assign tbl_wr.addr  = items.symbol;
    assign tbl_wr.code  = items.code_bits;
    assign tbl_wr.len   = cap_len(items.code_length);
    assign tbl_rd.en    = accept && (items.func == FUNC_ENCODE);
    assign tbl_rd.addr  = items.symbol;

    hcbp_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .rd_data (tbl_q)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept && (items.func == FUNC_ENCODE || items.func == FUNC_FINISH))
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // merge: left-align the code, slide it behind the pending bits
    always_comb
    begin
        s1_code    = s1_finish_reg ? end_bits_reg : tbl_q.code;
        s1_len     = s1_finish_reg ? cap_len(end_len_reg) : tbl_q.len;
        align_sh   = LEN_W'(CODE_W) - s1_len;
        code_al    = s1_code << align_sh;
        merged     = {pend_reg, {CODE_W{1'b0}}} | ({code_al, {BYTE_W{1'b0}}} >> pcnt_reg);
        total      = {{(LEN_W-PCNT_W){1'b0}}, pcnt_reg} + s1_len;
        full_bytes = total[LEN_W-1:PCNT_W];
        tail_bits  = total[PCNT_W-1:0];

        // the byte just after the full ones holds the leftover bits, zero padded
        unique case (full_bytes)
            3'd0:    tail_byte = merged[EMIT_W-1          -: BYTE_W];
            3'd1:    tail_byte = merged[EMIT_W-1-BYTE_W   -: BYTE_W];
            3'd2:    tail_byte = merged[EMIT_W-1-2*BYTE_W -: BYTE_W];
            3'd3:    tail_byte = merged[EMIT_W-1-3*BYTE_W -: BYTE_W];
            3'd4:    tail_byte = merged[EMIT_W-1-4*BYTE_W -: BYTE_W];
            default: tail_byte = merged[EMIT_W-1          -: BYTE_W];
        endcase

        if (s1_finish_reg)
        begin
            // finish flushes the partial byte and empties the accumulator
            emit_n    = full_bytes + CNT_W'(tail_bits != '0);
            pend_next = '0;
            pcnt_next = '0;
        end
        else
        begin
            emit_n    = full_bytes;
            pend_next = tail_byte;
            pcnt_next = tail_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_bits_reg <= '0;
            end_len_reg  <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_END_BITS: end_bits_reg <= cfg_data[CODE_W-1:0];
                REG_END_LEN:  end_len_reg  <= cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pend_reg     <= '0;
            pcnt_reg     <= '0;
            emit_cnt_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_fire)
            begin
                pend_reg     <= pend_next;
                pcnt_reg     <= pcnt_next;
                emit_cnt_reg <= emit_n;
            end
            else if (word_taken)
            begin
                emit_cnt_reg <= emit_cnt_reg - CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_finish_reg <= (items.func == FUNC_FINISH);
        end
        if (s1_fire)
        begin
            emit_reg <= merged;
        end
        else if (word_taken)
        begin
            emit_reg <= emit_reg << BYTE_W;
        end
    end

    assign words.valid    = (emit_cnt_reg != '0);
    assign words.out_byte = emit_reg[EMIT_W-1 -: BYTE_W];
    assign words.last     = (emit_cnt_reg == CNT_W'(1));

endmodule

// File: tb/huffman_code_bit_packer_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the prefix-code bit packer: directed and random items
// depends on hcbp_pkg, hcbp_if and the huffman_code_bit_packer rtl

module huffman_code_bit_packer_tb import hcbp_pkg::*; ();

    // func value that the packer must ignore
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int IDLE_PCT       = 12;   // chance in a hundred of a gap or a stall
    localparam int SETTLE_CYCLES  = 8;    // merge stage plus emitter, with margin
    localparam int WATCHDOG_LIMIT = 1000; // cycles with no handshake or register write
    localparam int PHASE_ITEMS    = 26;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } code_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } packed_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hcbp_item_if item_ch ();
    hcbp_word_if word_ch ();

    huffman_code_bit_packer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (item_ch),
        .words     (word_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // items waiting for the driver, and words the packer still owes us
    // newest entry at the front, oldest at the back
    code_item_t   item_backlog[$];
    packed_word_t expected_bytes[$];

    // symbols loaded so far, so that no encode ever touches an unwritten entry
    bit              sym_loaded[TBL_DEPTH];
    logic [SYM_W-1:0] loaded_syms[$];

    // shadow copy of the packer state
    logic [CODE_W-1:0] code_tbl[TBL_DEPTH] = '{default: '0};
    logic [LEN_W-1:0]  len_tbl[TBL_DEPTH]  = '{default: '0};
    logic [7:0]        acc_bits  = '0;   // pending bits, earliest highest
    int                acc_count = 0;
    logic [CODE_W-1:0] end_bits;
    logic [LEN_W-1:0]  end_len;

    logic item_taken;
    logic calm;                    // no gaps and no stalls while set
    int   mismatches   = 0;
    int   quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // lengths beyond the widest code saturate
    function automatic int clip_len(input int len);
        return (len > CAP_LEN_I) ? CAP_LEN_I : len;
    endfunction

    // shift a code in, first bit first, and emit every full byte
    task automatic append_code_bits(input logic [CODE_W-1:0] bits, input int len);
        for (int i = len; i > 0; i--)
        begin
            acc_bits = {acc_bits[6:0], bits[i-1]};
            acc_count++;
            if (acc_count == 8)
            begin
                expected_bytes.push_front('{out_byte: acc_bits, last: 1'b0});
                acc_bits  = '0;
                acc_count = 0;
            end
        end
    endtask

    task automatic predict_packed_bytes(input code_item_t it);
        int n_before;
        n_before = expected_bytes.size();
        case (it.func)
            FUNC_LOAD:
            begin
                code_tbl[it.symbol] = it.code_bits;
                len_tbl[it.symbol]  = LEN_W'(clip_len(it.code_length));
            end
            FUNC_ENCODE:
                append_code_bits(code_tbl[it.symbol], clip_len(len_tbl[it.symbol]));
            FUNC_FINISH:
            begin
                append_code_bits(end_bits, clip_len(end_len));
                // flush the partial byte, padded with zeros
                if (acc_count != 0)
                    expected_bytes.push_front('{out_byte: 8'(acc_bits << (8 - acc_count)),
                                                last: 1'b0});
                acc_bits  = '0;
                acc_count = 0;
            end
            default: ;
        endcase
        // the newest word sits at the front
        if (expected_bytes.size() > n_before)
            expected_bytes[0].last = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // item driver: changes at the falling edge, holds until taken
    // ---------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            item_taken <= item_ch.valid && item_ch.ready;
            if (item_ch.valid && item_ch.ready)
                predict_packed_bytes('{func: item_ch.func, symbol: item_ch.symbol,
                                       code_bits: item_ch.code_bits,
                                       code_length: item_ch.code_length});
        end
    end

    always @(negedge clk)
    begin : drive_items
        code_item_t nxt;
        if (!rst_n)
        begin
            item_ch.valid       <= 1'b0;
            item_ch.func        <= FUNC_LOAD;
            item_ch.symbol      <= '0;
            item_ch.code_bits   <= '0;
            item_ch.code_length <= '0;
        end
        else if (!item_ch.valid || item_taken)
        begin
            // a new item only once the last one has gone, with random gaps unless calm
            if (item_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                nxt = item_backlog.pop_back();
                item_ch.valid       <= 1'b1;
                item_ch.func        <= nxt.func;
                item_ch.symbol      <= nxt.symbol;
                item_ch.code_bits   <= nxt.code_bits;
                item_ch.code_length <= nxt.code_length;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // receiver stalls at random, never while calm
    always @(negedge clk)
        word_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // ---------------------------------------------------------------
    // word monitor: compares each taken word with the oldest prediction
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : check_words
        packed_word_t want;
        if (rst_n && word_ch.valid && word_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected word: out_byte %02h last %b", word_ch.out_byte, word_ch.last);
                mismatches++;
            end
            else
            begin
                want = expected_bytes.pop_back();
                if (word_ch.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, word_ch.out_byte);
                    mismatches++;
                end
                if (word_ch.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, word_ch.last);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: any handshake or register write counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (word_ch.valid && word_ch.ready) || cfg_we)
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("huffman_code_bit_packer: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic queue_item(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s,
                              input logic [CODE_W-1:0] b, input logic [LEN_W-1:0] l);
        item_backlog.push_front('{func: f, symbol: s, code_bits: b, code_length: l});
        if (f == FUNC_LOAD && !sym_loaded[s])
        begin
            sym_loaded[s] = 1'b1;
            loaded_syms.push_front(s);
        end
    endtask

    // mostly short codes, some empty, some saturating
    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 70)
            return LEN_W'($urandom_range(1, 12));
        else if (r < 90)
            return LEN_W'($urandom_range(13, 32));
        else
            return LEN_W'($urandom_range(33, 63));
    endfunction

    // hold the sender until the packer has drained, then let it settle
    // polled at the rising edge, where the driver never changes anything
    task automatic wait_quiet();
        while (item_backlog.size() != 0 || item_ch.valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_END_BITS)
            end_bits = data;
        else
            end_len = data[LEN_W-1:0];
    endtask

    // only the low bits of the length register matter, the rest carry noise
    task automatic set_end_code(input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
        wait_quiet();
        write_reg(REG_END_BITS, bits);
        write_reg(REG_END_LEN, {26'($urandom), len});
    endtask

    // a few fresh table entries, then a random mix of encodes, finishes, loads and ignored noise
    task automatic run_random_phase(input int n_items);
        int done;
        int roll;
        done = 0;
        repeat ($urandom_range(3, 6))
        begin
            queue_item(FUNC_LOAD, 8'($urandom_range(0, 255)), $urandom, pick_length());
            done++;
        end
        while (done < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 68)
                queue_item(FUNC_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                           $urandom, 6'($urandom));
            else if (roll < 82)
                queue_item(FUNC_FINISH, 8'($urandom), $urandom, 6'($urandom));
            else if (roll < 94)
                queue_item(FUNC_LOAD, 8'($urandom_range(0, 255)), $urandom, pick_length());
            else
            begin
                // noise the packer should ignore; not counted
                queue_item(FUNC_UNUSED, 8'($urandom), $urandom, 6'($urandom));
                continue;
            end
            done++;
        end
    endtask

    // ---------------------------------------------------------------
    // sequence of the run
    // ---------------------------------------------------------------

    initial
    begin
        cfg_we              = 1'b0;
        cfg_index           = REG_END_BITS;
        cfg_data            = '0;
        calm                = 1'b0;
        end_bits  = '0;
        end_len   = 6'd1;

        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset end code: one zero bit
        queue_item(FUNC_LOAD, 8'd0,   32'h0000_0000, 6'd0);   // symbol with no code
        queue_item(FUNC_LOAD, 8'd1,   32'h0000_0001, 6'd1);
        queue_item(FUNC_LOAD, 8'd2,   32'h0000_0000, 6'd32);  // all-zero longest code
        queue_item(FUNC_LOAD, 8'd3,   32'hA5A5_A5A5, 6'd63);  // overlong, saturates
        queue_item(FUNC_LOAD, 8'd4,   32'h0000_0005, 6'd3);
        queue_item(FUNC_LOAD, 8'd5,   32'h1234_5678, 6'd33);
        queue_item(FUNC_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
        queue_item(FUNC_ENCODE, 8'd1,   '0, '0);
        queue_item(FUNC_ENCODE, 8'd255, '0, '0);
        queue_item(FUNC_ENCODE, 8'd0,   '0, '0);               // appends nothing
        queue_item(FUNC_UNUSED, 8'd1,   32'hFFFF_FFFF, 6'd63);
        queue_item(FUNC_FINISH, 8'd0,   '0, '0);
        queue_item(FUNC_FINISH, 8'd0,   '0, '0);               // end code alone

        // longest all-ones end code: seven pending bits plus it give five words
        set_end_code(32'hFFFF_FFFF, 6'd32);
        queue_item(FUNC_ENCODE, 8'd4,   '0, '0);
        queue_item(FUNC_ENCODE, 8'd4,   '0, '0);
        queue_item(FUNC_ENCODE, 8'd1,   '0, '0);
        queue_item(FUNC_ENCODE, 8'd255, '0, '0);
        queue_item(FUNC_FINISH, 8'd0,   '0, '0);
        queue_item(FUNC_ENCODE, 8'd3,   '0, '0);
        queue_item(FUNC_FINISH, 8'd0,   '0, '0);

        // no end code: finish with nothing pending gives no word
        set_end_code(32'h0000_0000, 6'd0);
        queue_item(FUNC_FINISH, 8'd0, '0, '0);
        queue_item(FUNC_ENCODE, 8'd1, '0, '0);
        queue_item(FUNC_FINISH, 8'd0, '0, '0);
        queue_item(FUNC_ENCODE, 8'd2, '0, '0);

        // end code length beyond the limit saturates
        set_end_code(32'h8000_0001, 6'd63);
        queue_item(FUNC_ENCODE, 8'd5, '0, '0);
        queue_item(FUNC_FINISH, 8'd0, '0, '0);

        // random phases, each under its own end code; the middle one runs without gaps
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_end_code($urandom, 6'($urandom_range(1, 32)));
                1: set_end_code($urandom, 6'd0);
                2: set_end_code($urandom, 6'd32);
                3: set_end_code(32'h0000_0000, 6'd1);
                default: set_end_code($urandom, 6'($urandom_range(33, 63)));
            endcase
            calm = (ph == 2);
            run_random_phase(PHASE_ITEMS);
        end

        wait_quiet();
        if (mismatches == 0)
            $display("huffman_code_bit_packer: match");
        else
            $display("huffman_code_bit_packer: mismatch");
        $finish;
    end

endmodule
